// ----- hw/rtl/etf_pkg.sv -----
// ----------------------------------------------------------------------------
// Escape-time fractal iterator package
// Shared constants, register indexes, fractal mode codes and the control
// word that travels with each point from the front end to the iterator.
// ----------------------------------------------------------------------------
package etf_pkg;

   localparam int COUNT_WIDTH     = 16;
   localparam int MODE_WIDTH      = 3;
   localparam int CSR_INDEX_WIDTH = 2;
   localparam int QUEUE_DEPTH     = 2;

   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_ITERATION_LIMIT = 2'd0;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_FRACTAL_MODE    = 2'd1;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_JULIA_CONST_RE  = 2'd2;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_JULIA_CONST_IM  = 2'd3;

   localparam logic [MODE_WIDTH-1:0] MODE_MANDELBROT   = 3'd0;
   localparam logic [MODE_WIDTH-1:0] MODE_TRICORN      = 3'd1;
   localparam logic [MODE_WIDTH-1:0] MODE_BURNING_SHIP = 3'd2;
   localparam logic [MODE_WIDTH-1:0] MODE_JULIA        = 3'd3;
   localparam logic [MODE_WIDTH-1:0] MODE_CUBIC        = 3'd4;

   localparam logic [COUNT_WIDTH-1:0] LIMIT_RESET = 16'd256;
   localparam logic [MODE_WIDTH-1:0]  MODE_RESET  = MODE_MANDELBROT;

   typedef struct packed {
      logic cubic;
      logic inclusive;
      logic conjugate;
      logic fold;
   } iter_ctrl_type;

endpackage

// ----- hw/rtl/escape_time_fractal_iterator.sv -----
// ----------------------------------------------------------------------------
// Escape-time fractal iterator
// Iterates Mandelbrot, tricorn, burning ship, Julia or cubic multibrot
// for each complex point and returns the escape iteration count.
//
// Usage: a point (req_point_re, req_point_im, signed fixed point with
// FRACTION_BITS fraction bits) transfers when req_valid is high and
// req_stall is low. Each point gives exactly one rsp_iteration_count,
// which transfers when rsp_valid is high and rsp_stall is low.
// Write registers via csr_write_enable, csr_index and csr_write_data
// only while no point is in flight; the block does not enforce it.
// The iterator takes one point at a time and takes no new one until
// the last has left DONE. Each iteration passes through SQUARE and
// UPDATE, and in cubic mode also CUBE and CUBE_SUM; a point ends from
// SQUARE at the limit or from UPDATE on escape, then passes DONE.
// A front register and a two-entry queue take further points meanwhile.
// Reset: synchronous, clears the pipeline and sets the limit to 256,
// the mode to Mandelbrot and the Julia constant to zero.
// A stalled result holds in the output register; the iterator waits
// for that register and the queue then fills and stalls the requester.
// ----------------------------------------------------------------------------
module escape_time_fractal_iterator #(
   parameter int COORD_WIDTH   = 32,
   parameter int FRACTION_BITS = 28
) (
   input  logic                                   clock,
   input  logic                                   reset,
   input  logic                                   req_valid,
   output logic                                   req_stall,
   input  logic signed [COORD_WIDTH-1:0]          req_point_re,
   input  logic signed [COORD_WIDTH-1:0]          req_point_im,
   output logic                                   rsp_valid,
   input  logic                                   rsp_stall,
   output logic [etf_pkg::COUNT_WIDTH-1:0]        rsp_iteration_count,
   input  logic                                   csr_write_enable,
   input  logic [etf_pkg::CSR_INDEX_WIDTH-1:0]    csr_index,
   input  logic [COORD_WIDTH-1:0]                 csr_write_data
);

   localparam int EW = 4 * COORD_WIDTH + $bits(etf_pkg::iter_ctrl_type);

   logic [etf_pkg::COUNT_WIDTH-1:0] iteration_limit_ff, iteration_limit_in;
   logic [etf_pkg::MODE_WIDTH-1:0]  fractal_mode_ff, fractal_mode_in;
   logic [COORD_WIDTH-1:0]          julia_const_re_ff, julia_const_re_in;
   logic [COORD_WIDTH-1:0]          julia_const_im_ff, julia_const_im_in;

   logic          front_valid, front_stall;
   logic [EW-1:0] front_data;
   logic          queue_valid, queue_take;
   logic [EW-1:0] queue_data;

   always_comb begin
      iteration_limit_in = iteration_limit_ff;
      fractal_mode_in    = fractal_mode_ff;
      julia_const_re_in  = julia_const_re_ff;
      julia_const_im_in  = julia_const_im_ff;
      if (csr_write_enable) begin
         case (csr_index)
            etf_pkg::CSR_ITERATION_LIMIT: begin
               iteration_limit_in = csr_write_data[etf_pkg::COUNT_WIDTH-1:0];
            end
            etf_pkg::CSR_FRACTAL_MODE: begin
               fractal_mode_in = csr_write_data[etf_pkg::MODE_WIDTH-1:0];
            end
            etf_pkg::CSR_JULIA_CONST_RE: begin
               julia_const_re_in = csr_write_data;
            end
            etf_pkg::CSR_JULIA_CONST_IM: begin
               julia_const_im_in = csr_write_data;
            end
            default: begin
               iteration_limit_in = iteration_limit_ff;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         iteration_limit_ff <= etf_pkg::LIMIT_RESET;
         fractal_mode_ff    <= etf_pkg::MODE_RESET;
         julia_const_re_ff  <= '0;
         julia_const_im_ff  <= '0;
      end else begin
         iteration_limit_ff <= iteration_limit_in;
         fractal_mode_ff    <= fractal_mode_in;
         julia_const_re_ff  <= julia_const_re_in;
         julia_const_im_ff  <= julia_const_im_in;
      end
   end

   etf_front #(
      .COORD_WIDTH (COORD_WIDTH)
   ) u_front (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_stall      (req_stall),
      .req_point_re   (req_point_re),
      .req_point_im   (req_point_im),
      .fractal_mode   (fractal_mode_ff),
      .julia_const_re (julia_const_re_ff),
      .julia_const_im (julia_const_im_ff),
      .entry_valid    (front_valid),
      .entry_stall    (front_stall),
      .entry_data     (front_data)
   );

   etf_queue #(
      .WIDTH (EW),
      .DEPTH (etf_pkg::QUEUE_DEPTH)
   ) u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (front_valid),
      .push_stall (front_stall),
      .push_data  (front_data),
      .pop_valid  (queue_valid),
      .pop_take   (queue_take),
      .pop_data   (queue_data)
   );

   etf_core #(
      .COORD_WIDTH   (COORD_WIDTH),
      .FRACTION_BITS (FRACTION_BITS)
   ) u_core (
      .clock               (clock),
      .reset               (reset),
      .entry_valid         (queue_valid),
      .entry_take          (queue_take),
      .entry_data          (queue_data),
      .iteration_limit     (iteration_limit_ff),
      .rsp_valid           (rsp_valid),
      .rsp_stall           (rsp_stall),
      .rsp_iteration_count (rsp_iteration_count)
   );

endmodule

// ----- hw/rtl/etf_front.sv -----
// ----------------------------------------------------------------------------
// Escape-time fractal front end
// Accepts points, resolves the fractal mode into a control word and the
// starting values of z and c, and holds one entry for the point queue.
// ----------------------------------------------------------------------------
module etf_front #(
   parameter int COORD_WIDTH = 32
) (
   input  logic                                   clock,
   input  logic                                   reset,
   input  logic                                   req_valid,
   output logic                                   req_stall,
   input  logic signed [COORD_WIDTH-1:0]          req_point_re,
   input  logic signed [COORD_WIDTH-1:0]          req_point_im,
   input  logic [etf_pkg::MODE_WIDTH-1:0]         fractal_mode,
   input  logic [COORD_WIDTH-1:0]                 julia_const_re,
   input  logic [COORD_WIDTH-1:0]                 julia_const_im,
   output logic                                   entry_valid,
   input  logic                                   entry_stall,
   output logic [4*COORD_WIDTH+$bits(etf_pkg::iter_ctrl_type)-1:0] entry_data
);

   logic                          entry_valid_ff, entry_valid_in;
   logic [COORD_WIDTH-1:0]        zr_ff, zr_in, zi_ff, zi_in, cr_ff, cr_in, ci_ff, ci_in;
   etf_pkg::iter_ctrl_type        ctrl_ff, ctrl_in;
   logic                          accept;

   assign req_stall   = entry_valid_ff & entry_stall;
   assign accept      = req_valid & ~req_stall;
   assign entry_valid = entry_valid_ff;
   assign entry_data  = {ctrl_ff, zr_ff, zi_ff, cr_ff, ci_ff};

   always_comb begin
      etf_pkg::iter_ctrl_type ctrl;
      ctrl           = '0;
      entry_valid_in = accept | (entry_valid_ff & entry_stall);
      zr_in          = zr_ff;
      zi_in          = zi_ff;
      cr_in          = cr_ff;
      ci_in          = ci_ff;
      ctrl_in        = ctrl_ff;
      case (fractal_mode)
         etf_pkg::MODE_TRICORN: begin
            ctrl.conjugate = 1'b1;
         end
         etf_pkg::MODE_BURNING_SHIP: begin
            ctrl.fold      = 1'b1;
            ctrl.inclusive = 1'b1;
         end
         etf_pkg::MODE_JULIA: begin
            ctrl.inclusive = 1'b1;
         end
         etf_pkg::MODE_CUBIC: begin
            ctrl.cubic = 1'b1;
         end
         default: begin
            ctrl = '0;
         end
      endcase
      if (accept) begin
         ctrl_in = ctrl;
         if (fractal_mode == etf_pkg::MODE_JULIA) begin
            zr_in = req_point_re;
            zi_in = req_point_im;
            cr_in = julia_const_re;
            ci_in = julia_const_im;
         end else begin
            zr_in = '0;
            zi_in = '0;
            cr_in = req_point_re;
            ci_in = req_point_im;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         entry_valid_ff <= 1'b0;
      end else begin
         entry_valid_ff <= entry_valid_in;
      end
      zr_ff   <= zr_in;
      zi_ff   <= zi_in;
      cr_ff   <= cr_in;
      ci_ff   <= ci_in;
      ctrl_ff <= ctrl_in;
   end

endmodule

// ----- hw/rtl/etf_queue.sv -----
// ----------------------------------------------------------------------------
// Escape-time fractal point queue
// A short first-in first-out buffer between the front end and the
// iterator, so that each side can stall on its own.
// ----------------------------------------------------------------------------
module etf_queue #(
   parameter int WIDTH = 132,
   parameter int DEPTH = 2
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             push_valid,
   output logic             push_stall,
   input  logic [WIDTH-1:0] push_data,
   output logic             pop_valid,
   input  logic             pop_take,
   output logic [WIDTH-1:0] pop_data
);

   localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int FW = $clog2(DEPTH + 1);

   logic [WIDTH-1:0] slot_ff [DEPTH];
   logic [PW-1:0]    wr_ptr_ff, wr_ptr_in, rd_ptr_ff, rd_ptr_in;
   logic [FW-1:0]    fill_ff, fill_in;
   logic             push, pop;

   assign push_stall = (fill_ff == FW'(DEPTH));
   assign pop_valid  = (fill_ff != '0);
   assign push       = push_valid & ~push_stall;
   assign pop        = pop_valid & pop_take;
   assign pop_data   = slot_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      fill_in   = fill_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == PW'(DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == PW'(DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (push && !pop) begin
         fill_in = fill_ff + 1'b1;
      end else if (pop && !push) begin
         fill_in = fill_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         fill_ff   <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         fill_ff   <= fill_in;
      end
      if (push) begin
         slot_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule

// ----- hw/rtl/etf_core.sv -----
// ----------------------------------------------------------------------------
// Escape-time fractal iterator core
// Takes one queued point at a time, iterates it with saturating fixed-point
// arithmetic until it escapes or reaches the limit, and holds the count in
// an output register until the receiver takes it.
// ----------------------------------------------------------------------------
module etf_core #(
   parameter int COORD_WIDTH   = 32,
   parameter int FRACTION_BITS = 28
) (
   input  logic                                   clock,
   input  logic                                   reset,
   input  logic                                   entry_valid,
   output logic                                   entry_take,
   input  logic [4*COORD_WIDTH+$bits(etf_pkg::iter_ctrl_type)-1:0] entry_data,
   input  logic [etf_pkg::COUNT_WIDTH-1:0]        iteration_limit,
   output logic                                   rsp_valid,
   input  logic                                   rsp_stall,
   output logic [etf_pkg::COUNT_WIDTH-1:0]        rsp_iteration_count
);

   localparam int W    = COORD_WIDTH;
   localparam int CNTW = etf_pkg::COUNT_WIDTH;
   localparam int CW   = (W + 1 > FRACTION_BITS + 3) ? W + 1 : FRACTION_BITS + 3;

   localparam logic [W-1:0]   VMAX      = {1'b0, {(W-1){1'b1}}};
   localparam logic [W-1:0]   VMIN      = {1'b1, {(W-1){1'b0}}};
   localparam logic [2*W-1:0] HALF_WIDE = (2*W)'(1) << (W - 1);
   localparam logic [2*W-1:0] MAX_WIDE  = HALF_WIDE - 1'b1;
   localparam logic [CW-1:0]  BOUND     = CW'(4) << FRACTION_BITS;

   typedef enum logic [2:0] {
      IDLE,
      SQUARE,
      UPDATE,
      CUBE,
      CUBE_SUM,
      DONE
   } state_type;

   state_type              state_ff, state_in;
   logic [W-1:0]           zr_ff, zr_in, zi_ff, zi_in, cr_ff, cr_in, ci_ff, ci_in;
   logic [W-1:0]           sr_ff, sr_in, si_ff, si_in, p_ff, p_in;
   logic [W-1:0]           q0_ff, q0_in, q1_ff, q1_in, q2_ff, q2_in, q3_ff, q3_in;
   etf_pkg::iter_ctrl_type ctrl_ff, ctrl_in;
   logic [CNTW-1:0]        count_ff, count_in;
   logic                   rsp_valid_ff, rsp_valid_in;
   logic [CNTW-1:0]        rsp_iteration_count_ff, rsp_iteration_count_in;
   logic [CW-1:0]          magnitude;
   logic                   escape;

   function automatic logic [W-1:0] fx_mul(input logic [W-1:0] a, input logic [W-1:0] b);
      logic           neg;
      logic [W-1:0]   ua, ub;
      logic [2*W-1:0] prod, mag;
      neg  = a[W-1] ^ b[W-1];
      ua   = a[W-1] ? (~a + 1'b1) : a;
      ub   = b[W-1] ? (~b + 1'b1) : b;
      prod = {{W{1'b0}}, ua} * {{W{1'b0}}, ub};
      mag  = prod >> FRACTION_BITS;
      if (neg) begin
         fx_mul = (mag >= HALF_WIDE) ? VMIN : (~mag[W-1:0] + 1'b1);
      end else begin
         fx_mul = (mag >= MAX_WIDE) ? VMAX : mag[W-1:0];
      end
   endfunction

   function automatic logic [W-1:0] sat_add(input logic [W-1:0] a, input logic [W-1:0] b);
      logic [W:0] s;
      s = {a[W-1], a} + {b[W-1], b};
      if (s[W] != s[W-1]) begin
         sat_add = s[W] ? VMIN : VMAX;
      end else begin
         sat_add = s[W-1:0];
      end
   endfunction

   function automatic logic [W-1:0] sat_sub(input logic [W-1:0] a, input logic [W-1:0] b);
      logic [W:0] s;
      s = {a[W-1], a} - {b[W-1], b};
      if (s[W] != s[W-1]) begin
         sat_sub = s[W] ? VMIN : VMAX;
      end else begin
         sat_sub = s[W-1:0];
      end
   endfunction

   function automatic logic [W-1:0] sat_abs(input logic [W-1:0] a);
      if (!a[W-1]) begin
         sat_abs = a;
      end else if (a == VMIN) begin
         sat_abs = VMAX;
      end else begin
         sat_abs = ~a + 1'b1;
      end
   endfunction

   function automatic logic [W-1:0] sat_triple(input logic [W-1:0] a);
      sat_triple = sat_add(sat_add(a, a), a);
   endfunction

   // The squares are never negative, so the escape sum is taken unsigned.
   assign magnitude  = CW'(sr_ff) + CW'(si_ff);
   assign escape     = ctrl_ff.inclusive ? (magnitude > BOUND) : (magnitude >= BOUND);
   assign entry_take = (state_ff == IDLE) & entry_valid;

   assign rsp_valid           = rsp_valid_ff;
   assign rsp_iteration_count = rsp_iteration_count_ff;

   always_comb begin
      logic [W-1:0] d;
      state_in               = state_ff;
      zr_in                  = zr_ff;
      zi_in                  = zi_ff;
      cr_in                  = cr_ff;
      ci_in                  = ci_ff;
      sr_in                  = sr_ff;
      si_in                  = si_ff;
      p_in                   = p_ff;
      q0_in                  = q0_ff;
      q1_in                  = q1_ff;
      q2_in                  = q2_ff;
      q3_in                  = q3_ff;
      ctrl_in                = ctrl_ff;
      count_in               = count_ff;
      rsp_valid_in           = rsp_valid_ff & rsp_stall;
      rsp_iteration_count_in = rsp_iteration_count_ff;
      d                      = sat_add(p_ff, p_ff);
      if (ctrl_ff.conjugate) begin
         d = sat_sub('0, d);
      end else if (ctrl_ff.fold) begin
         d = sat_abs(d);
      end
      case (state_ff)
         IDLE: begin
            if (entry_valid) begin
               {ctrl_in, zr_in, zi_in, cr_in, ci_in} = entry_data;
               count_in = '0;
               state_in = SQUARE;
            end
         end
         SQUARE: begin
            if (count_ff >= iteration_limit) begin
               state_in = DONE;
            end else begin
               sr_in    = fx_mul(zr_ff, zr_ff);
               si_in    = fx_mul(zi_ff, zi_ff);
               p_in     = fx_mul(zi_ff, zr_ff);
               state_in = UPDATE;
            end
         end
         UPDATE: begin
            if (escape) begin
               state_in = DONE;
            end else if (ctrl_ff.cubic) begin
               state_in = CUBE;
            end else begin
               zr_in    = sat_add(sat_sub(sr_ff, si_ff), cr_ff);
               zi_in    = sat_add(d, ci_ff);
               count_in = count_ff + 1'b1;
               state_in = SQUARE;
            end
         end
         CUBE: begin
            q0_in    = fx_mul(sr_ff, zr_ff);
            q1_in    = fx_mul(zr_ff, si_ff);
            q2_in    = fx_mul(sr_ff, zi_ff);
            q3_in    = fx_mul(si_ff, zi_ff);
            state_in = CUBE_SUM;
         end
         CUBE_SUM: begin
            zr_in    = sat_add(sat_sub(q0_ff, sat_triple(q1_ff)), cr_ff);
            zi_in    = sat_add(sat_sub(sat_triple(q2_ff), q3_ff), ci_ff);
            count_in = count_ff + 1'b1;
            state_in = SQUARE;
         end
         DONE: begin
            if (!rsp_valid_ff || !rsp_stall) begin
               rsp_valid_in           = 1'b1;
               rsp_iteration_count_in = count_ff;
               state_in               = IDLE;
            end
         end
         default: begin
            state_in = IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      zr_ff                  <= zr_in;
      zi_ff                  <= zi_in;
      cr_ff                  <= cr_in;
      ci_ff                  <= ci_in;
      sr_ff                  <= sr_in;
      si_ff                  <= si_in;
      p_ff                   <= p_in;
      q0_ff                  <= q0_in;
      q1_ff                  <= q1_in;
      q2_ff                  <= q2_in;
      q3_ff                  <= q3_in;
      ctrl_ff                <= ctrl_in;
      count_ff               <= count_in;
      rsp_iteration_count_ff <= rsp_iteration_count_in;
   end

`ifndef ASSERT_OFF
   a_count_within_limit: assert property (@(posedge clock) disable iff (reset)
      (state_ff == SQUARE) |-> (count_ff <= iteration_limit))
      else $error("Iteration count passed the limit.");

   a_take_starts_point: assert property (@(posedge clock) disable iff (reset)
      entry_take |=> (state_ff == SQUARE && count_ff == {CNTW{1'b0}}))
      else $error("A taken point did not start from a zero count.");

   a_cubic_step_counts: assert property (@(posedge clock) disable iff (reset)
      (state_ff == CUBE_SUM) |=>
         (state_ff == SQUARE && count_ff == CNTW'($past(count_ff) + 1'b1)))
      else $error("A cubic step did not advance the count by one.");

   a_result_loaded: assert property (@(posedge clock) disable iff (reset)
      (state_ff == DONE && (!rsp_valid_ff || !rsp_stall)) |=>
         (rsp_valid_ff && rsp_iteration_count_ff == $past(count_ff)))
      else $error("A finished count did not reach the output register.");
`endif

endmodule

// ----- test/escape_time_fractal_iterator_tb.sv -----
// ----------------------------------------------------------------------------
// Escape-time fractal iterator testbench
// Sends complex points through the request channel and checks every returned
// iteration count against a fixed-point predictor that runs the same escape
// loop. Directed tests cover the reset settings, every mode code, the limit
// extremes and a long output stall; random traffic then runs with changing
// settings, with both sides idling at random in two of its three phases.
// ----------------------------------------------------------------------------
module escape_time_fractal_iterator_tb;

   timeunit 1ns;
   timeprecision 1ps;

   localparam int     COORD_WIDTH       = 32;
   localparam int     FRACTION_BITS     = 28;
   localparam int     CLOCK_PERIOD      = 10;
   localparam int     RESET_CYCLES      = 7;
   localparam int     DRAIN_CYCLES      = 10;
   localparam int     STALL_HOLD_CYCLES = 300;
   localparam int     PHASE_POINTS      = 460;
   localparam longint TIMEOUT_CYCLES    = 20_000_000;

   localparam longint COORD_MAX = (64'sd1 <<< (COORD_WIDTH - 1)) - 1;
   localparam longint COORD_MIN = -COORD_MAX - 1;
   localparam longint ONE       = 64'sd1 <<< FRACTION_BITS;
   localparam longint BOUND     = 4 * ONE;

   localparam logic [etf_pkg::MODE_WIDTH-1:0]  MODE_LAST_CODE = '1;
   localparam logic [etf_pkg::COUNT_WIDTH-1:0] LIMIT_MAX      = '1;

   typedef logic signed [COORD_WIDTH-1:0] coord_type;

   logic                                clock            = 1'b0;
   logic                                reset            = 1'b1;
   logic                                req_valid        = 1'b0;
   logic                                req_stall;
   coord_type                           req_point_re     = '0;
   coord_type                           req_point_im     = '0;
   logic                                rsp_valid;
   logic                                rsp_stall        = 1'b0;
   logic [etf_pkg::COUNT_WIDTH-1:0]     rsp_iteration_count;
   logic                                csr_write_enable = 1'b0;
   logic [etf_pkg::CSR_INDEX_WIDTH-1:0] csr_index        = etf_pkg::CSR_ITERATION_LIMIT;
   logic [COORD_WIDTH-1:0]              csr_write_data   = '0;

   logic [etf_pkg::COUNT_WIDTH-1:0] limit_setting = etf_pkg::LIMIT_RESET;
   logic [etf_pkg::MODE_WIDTH-1:0]  mode_setting  = etf_pkg::MODE_RESET;
   coord_type                       julia_re      = '0;
   coord_type                       julia_im      = '0;

   logic [etf_pkg::COUNT_WIDTH-1:0] pending_counts[$];
   int                              send_idle_pct    = 0;
   int                              recv_idle_pct    = 0;
   int                              hold_cycles_left = 0;
   bit                              failure_seen     = 1'b0;

   escape_time_fractal_iterator #(
      .COORD_WIDTH   (COORD_WIDTH),
      .FRACTION_BITS (FRACTION_BITS)
   ) dut (
      .clock               (clock),
      .reset               (reset),
      .req_valid           (req_valid),
      .req_stall           (req_stall),
      .req_point_re        (req_point_re),
      .req_point_im        (req_point_im),
      .rsp_valid           (rsp_valid),
      .rsp_stall           (rsp_stall),
      .rsp_iteration_count (rsp_iteration_count),
      .csr_write_enable    (csr_write_enable),
      .csr_index           (csr_index),
      .csr_write_data      (csr_write_data)
   );

   always #(CLOCK_PERIOD / 2) clock = ~clock;

   function automatic longint clip_coord(input longint v);
      if (v > COORD_MAX) return COORD_MAX;
      if (v < COORD_MIN) return COORD_MIN;
      return v;
   endfunction

   function automatic longint q_mul(input longint a, input longint b);
      longint mag;
      mag = ((a < 0 ? -a : a) * (b < 0 ? -b : b)) >> FRACTION_BITS;
      return clip_coord(((a < 0) != (b < 0)) ? -mag : mag);
   endfunction

   function automatic logic [etf_pkg::COUNT_WIDTH-1:0] escape_count(input coord_type re,
                                                                    input coord_type im);
      longint                         zr, zi, cr, ci, sr, si, nr, ni, t1, t2, d;
      logic [etf_pkg::MODE_WIDTH-1:0] m;
      int unsigned                    n;
      bit                             escaped;
      m  = (mode_setting > etf_pkg::MODE_CUBIC) ? etf_pkg::MODE_MANDELBROT : mode_setting;
      zr = 0;
      zi = 0;
      cr = re;
      ci = im;
      if (m == etf_pkg::MODE_JULIA) begin
         zr = re;
         zi = im;
         cr = julia_re;
         ci = julia_im;
      end
      n       = 0;
      escaped = 1'b0;
      while (!escaped && n < limit_setting) begin
         sr = q_mul(zr, zr);
         si = q_mul(zi, zi);
         if (m == etf_pkg::MODE_BURNING_SHIP || m == etf_pkg::MODE_JULIA) begin
            escaped = (sr + si > BOUND);
         end else begin
            escaped = (sr + si >= BOUND);
         end
         if (!escaped) begin
            if (m == etf_pkg::MODE_CUBIC) begin
               t1 = q_mul(zr, si);
               t2 = q_mul(sr, zi);
               t1 = clip_coord(clip_coord(t1 + t1) + t1);
               t2 = clip_coord(clip_coord(t2 + t2) + t2);
               nr = clip_coord(clip_coord(q_mul(sr, zr) - t1) + cr);
               ni = clip_coord(clip_coord(t2 - q_mul(si, zi)) + ci);
            end else begin
               d = q_mul(zi, zr);
               d = clip_coord(d + d);
               if (m == etf_pkg::MODE_TRICORN) d = clip_coord(-d);
               else if (m == etf_pkg::MODE_BURNING_SHIP) d = clip_coord(d < 0 ? -d : d);
               nr = clip_coord(clip_coord(sr - si) + cr);
               ni = clip_coord(d + ci);
            end
            zr = nr;
            zi = ni;
            n++;
         end
      end
      return etf_pkg::COUNT_WIDTH'(n);
   endfunction

   function automatic coord_type random_coord();
      longint span;
      span = 5 * ONE / 2;
      case ($urandom_range(9))
         0: return coord_type'($urandom);
         1: begin
            case ($urandom_range(3))
               0: return coord_type'(COORD_MIN);
               1: return coord_type'(COORD_MAX);
               2: return coord_type'(2 * ONE);
               default: return coord_type'(-2 * ONE);
            endcase
         end
         default: return coord_type'(longint'($urandom_range(0, 32'(2 * span))) - span);
      endcase
   endfunction

   function automatic coord_type random_julia_part();
      case ($urandom_range(7))
         0: return coord_type'($urandom);
         1: return coord_type'($urandom_range(1) ? COORD_MIN : COORD_MAX);
         default: return coord_type'(longint'($urandom_range(0, 32'(2 * ONE))) - ONE);
      endcase
   endfunction

   task automatic write_register(input logic [etf_pkg::CSR_INDEX_WIDTH-1:0] index,
                                 input logic [COORD_WIDTH-1:0] value);
      @(negedge clock);
      csr_write_enable <= 1'b1;
      csr_index        <= index;
      csr_write_data   <= value;
      @(negedge clock);
      csr_write_enable <= 1'b0;
      case (index)
         etf_pkg::CSR_ITERATION_LIMIT: limit_setting = value[etf_pkg::COUNT_WIDTH-1:0];
         etf_pkg::CSR_FRACTAL_MODE:    mode_setting  = value[etf_pkg::MODE_WIDTH-1:0];
         etf_pkg::CSR_JULIA_CONST_RE:  julia_re      = value;
         etf_pkg::CSR_JULIA_CONST_IM:  julia_im      = value;
         default:                      limit_setting = limit_setting;
      endcase
   endtask

   task automatic configure(input logic [etf_pkg::COUNT_WIDTH-1:0] limit,
                            input logic [etf_pkg::MODE_WIDTH-1:0] mode,
                            input coord_type c_re, input coord_type c_im);
      write_register(etf_pkg::CSR_ITERATION_LIMIT, COORD_WIDTH'(limit));
      write_register(etf_pkg::CSR_FRACTAL_MODE, COORD_WIDTH'(mode));
      write_register(etf_pkg::CSR_JULIA_CONST_RE, c_re);
      write_register(etf_pkg::CSR_JULIA_CONST_IM, c_im);
   endtask

   task automatic send_point(input coord_type re, input coord_type im);
      while ($urandom_range(99) < send_idle_pct) begin
         @(negedge clock);
         req_valid <= 1'b0;
      end
      @(negedge clock);
      req_valid    <= 1'b1;
      req_point_re <= re;
      req_point_im <= im;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      pending_counts.push_back(escape_count(re, im));
   endtask

   task automatic wait_for_results();
      @(negedge clock);
      req_valid <= 1'b0;
      while (pending_counts.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   // Result checker: every transfer on the result channel takes the oldest prediction.
   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall) begin
         if (pending_counts.size() == 0) begin
            $error("iteration_count: unexpected transfer, actual %0d", rsp_iteration_count);
            failure_seen <= 1'b1;
         end else begin
            if (rsp_iteration_count !== pending_counts[0]) begin
               $error("iteration_count: expected %0d, actual %0d",
                      pending_counts[0], rsp_iteration_count);
               failure_seen <= 1'b1;
            end
            void'(pending_counts.pop_front());
         end
      end
   end

   always @(negedge clock) begin
      if (hold_cycles_left > 0) begin
         rsp_stall        <= 1'b1;
         hold_cycles_left <= hold_cycles_left - 1;
      end else begin
         rsp_stall <= ($urandom_range(99) < recv_idle_pct);
      end
   end

   task automatic test_reset_settings();
      send_point('0, '0);
      send_point(coord_type'(2 * ONE), '0);
      send_point(coord_type'(-2 * ONE), '0);
      send_point(coord_type'(COORD_MAX), coord_type'(COORD_MAX));
      send_point(coord_type'(COORD_MIN), coord_type'(COORD_MIN));
      wait_for_results();
   endtask

   task automatic test_each_mode();
      logic [etf_pkg::MODE_WIDTH-1:0] mode;
      mode = etf_pkg::MODE_MANDELBROT;
      repeat (2 ** etf_pkg::MODE_WIDTH) begin
         configure(etf_pkg::COUNT_WIDTH'(100), mode, coord_type'(-4 * ONE / 5),
                   coord_type'(ONE * 39 / 250));
         send_point(coord_type'(3 * ONE / 10), coord_type'(-3 * ONE / 5));
         send_point(coord_type'(2 * ONE), '0);
         wait_for_results();
         mode++;
      end
   endtask

   task automatic test_limit_extremes();
      configure('0, etf_pkg::MODE_MANDELBROT, '0, '0);
      send_point('0, '0);
      send_point(coord_type'(COORD_MAX), coord_type'(COORD_MIN));
      wait_for_results();
      configure(etf_pkg::COUNT_WIDTH'(1), etf_pkg::MODE_CUBIC, '0, '0);
      send_point('0, '0);
      wait_for_results();
      configure(LIMIT_MAX, etf_pkg::MODE_MANDELBROT, '0, '0);
      send_point('0, '0);
      wait_for_results();
   endtask

   task automatic test_output_backpressure();
      configure(etf_pkg::COUNT_WIDTH'(12), etf_pkg::MODE_JULIA, coord_type'(COORD_MIN),
                coord_type'(COORD_MAX));
      send_idle_pct = 0;
      recv_idle_pct = 0;
      @(posedge clock);
      hold_cycles_left = STALL_HOLD_CYCLES;
      repeat (12) send_point(random_coord(), random_coord());
      wait_for_results();
   endtask

   task automatic test_random_points(input int send_pct, input int recv_pct);
      int                              sent;
      int                              batch;
      logic [etf_pkg::COUNT_WIDTH-1:0] limit;
      logic [etf_pkg::MODE_WIDTH-1:0]  mode;
      send_idle_pct = send_pct;
      recv_idle_pct = recv_pct;
      sent          = 0;
      while (sent < PHASE_POINTS) begin
         case ($urandom_range(7))
            0: limit = etf_pkg::COUNT_WIDTH'($urandom_range(100, 300));
            1: limit = etf_pkg::COUNT_WIDTH'($urandom_range(1, 4));
            default: limit = etf_pkg::COUNT_WIDTH'($urandom_range(5, 48));
         endcase
         if ($urandom_range(9) == 0) begin
            mode = etf_pkg::MODE_WIDTH'($urandom_range(etf_pkg::MODE_CUBIC + 1,
                                                       MODE_LAST_CODE));
         end else begin
            mode = etf_pkg::MODE_WIDTH'($urandom_range(etf_pkg::MODE_MANDELBROT,
                                                       etf_pkg::MODE_CUBIC));
         end
         configure(limit, mode, random_julia_part(), random_julia_part());
         batch = $urandom_range(20, 40);
         repeat (batch) send_point(random_coord(), random_coord());
         sent += batch;
         wait_for_results();
      end
   endtask

   initial begin
      repeat (RESET_CYCLES) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      test_reset_settings();
      test_each_mode();
      test_limit_extremes();
      test_output_backpressure();
      test_random_points(31, 82);
      test_random_points(82, 31);
      test_random_points(0, 0);
      wait_for_results();
      if (failure_seen) begin
         $display("escape_time_fractal_iterator verification failed");
      end else begin
         $display("escape_time_fractal_iterator verification clean");
      end
      $finish;
   end

   initial begin
      #(TIMEOUT_CYCLES * CLOCK_PERIOD);
      $display("escape_time_fractal_iterator verification failed");
      $finish;
   end

endmodule
